### hdl/pes_pkg.sv
`default_nettype none
package pes_pkg;
	localparam int POS_W = 32;
	localparam int DIR_W = 16;
	localparam int RES_W = 31;
	localparam int CFG_W = 31;
	localparam int MAX_DIVISIONS_DEF = 32;
	localparam logic [RES_W-1:0] RES_RESET = 31'd65536;

	localparam logic [0:0] REG_CLOSED = 1'd0;
	localparam logic [0:0] REG_RES = 1'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RR,
		S_LEN_MUL,
		S_LEN_ACC,
		S_CNT_INIT,
		S_CNT,
		S_DIV_GO,
		S_DIV_WAIT,
		S_PT_INIT,
		S_PT_CALC,
		S_ECHO,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

### hdl/polyline_edge_subdivider.sv
`default_nettype none
// Polyline edge subdivider. Nodes arrive one per item; the first node of a run is echoed,
// every later node splits the edge from the previous node into round(length/resolution)
// equal parts (at least one, at most MAX_DIVISIONS) and emits one point per part, and in
// closed mode the last node also walks the edge back to the first node without repeating
// it. One item is in flight at a time and s_tready is high only while idle. Per edge the
// block computes the squared length in a shared 32x32 multiplier, runs a set-up state and
// a running compare against the squared resolution over division counts up to
// MAX_DIVISIONS+1, runs a bit-serial divider once per axis for the per-part step, then
// passes a calculate state and an output state per result; m_tready can stall the latter.
module polyline_edge_subdivider #(
	parameter int MAX_DIVISIONS = pes_pkg::MAX_DIVISIONS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [0:0]               cfg_idx,
	input  wire logic [pes_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
	input  wire logic [143:0]             s_tdata,
	// first_node
	input  wire logic [0:0]               s_tuser,
	input  wire logic                     s_tlast,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// out_x, out_y, out_z, edge_dir_x, edge_dir_y, edge_dir_z
	output logic [143:0]                  m_tdata,
	// has_edge, divisions_clipped
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);
	localparam int PW = pes_pkg::POS_W;
	localparam int DRW = pes_pkg::DIR_W;
	localparam int NW = $clog2(MAX_DIVISIONS + 1);
	localparam int KW = $clog2(MAX_DIVISIONS + 2);
	localparam int RW = NW + 2;
	localparam int LW = 66;
	localparam int SW = 68 + 2 * $clog2(2 * MAX_DIVISIONS + 2);

	pes_pkg::state_t state_q, state_d;

	logic                     closed_q;
	logic [pes_pkg::RES_W-1:0] res_q;
	logic                     started_q;
	logic                     echo_q, do_b_q, last_q;
	logic                     edge_q;
	logic [1:0]               ax_q;
	logic [KW-1:0]            k_q, ncnt_q;
	logic [NW-1:0]            pk_q;
	logic [NW-1:0]            n_q [2];
	logic                     clip_q [2];

	logic [PW-1:0]  cur_q [3];
	logic [DRW-1:0] dir_q [3];
	logic [PW-1:0]  start_q [3];
	logic [PW-1:0]  prev_q [3];
	logic [DRW-1:0] pdir_q [3];

	logic [61:0]    rr_q;
	logic [63:0]    prod_q;
	logic [LW-1:0]  len_q;
	logic [SW-1:0]  s_q, d_q;
	logic [PW-1:0]  q0_q [3];
	logic [NW:0]    r0_q [3];
	logic [PW-1:0]  q_q [3];
	logic [RW-1:0]  rem_q [3];
	logic [PW-1:0]  ox_q [3];
	logic [DRW-1:0] od_q [3];
	logic           o_has_q, o_clip_q, o_last_q, part_end_q;

	logic [PW-1:0]  pos_in [3];
	logic [DRW-1:0] dir_in [3];
	logic           echo_w;

	logic [PW-1:0]  from_w [3];
	logic [PW-1:0]  to_w [3];
	logic [PW:0]    diff_w [3];
	logic [PW:0]    negd_w [3];
	logic           neg_w [3];
	logic [PW-1:0]  mag_w [3];
	logic [DRW-1:0] edir_w [3];

	logic [pes_pkg::RES_W-1:0] r_eff;
	logic [PW-1:0]  mul_a;
	logic [63:0]    product;

	logic [67:0]    len4;
	logic           ge;
	logic           cnt_stop;
	logic [KW-1:0]  ncnt_fin;
	logic [NW-1:0]  n_fin;
	logic           clip_fin;

	logic [NW-1:0]  n_sel;
	logic [NW-1:0]  klast_w;
	logic           emits_b;
	logic [NW-1:0]  pk_nx;
	logic           pk_end;

	logic [RW-1:0]  two_n;
	logic [RW-1:0]  sum_r [3];
	logic           carry_w [3];
	logic [RW-1:0]  rem_nx [3];
	logic [PW-1:0]  q_nx [3];
	logic [PW:0]    qx_w [3];
	logic [PW:0]    fx_w [3];
	logic [PW:0]    pos_w [3];

	pes_pkg::div_ctl_t div_in, div_out;
	logic [PW-1:0]  div_quot;
	logic [NW-1:0]  div_rem;

	assign pos_in[0] = s_tdata[31:0];
	assign pos_in[1] = s_tdata[63:32];
	assign pos_in[2] = s_tdata[95:64];
	assign dir_in[0] = s_tdata[111:96];
	assign dir_in[1] = s_tdata[127:112];
	assign dir_in[2] = s_tdata[143:128];
	assign echo_w = s_tuser[0] || !started_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			from_w[i] = edge_q ? cur_q[i] : prev_q[i];
			to_w[i] = edge_q ? start_q[i] : cur_q[i];
			diff_w[i] = {to_w[i][PW-1], to_w[i]} - {from_w[i][PW-1], from_w[i]};
			negd_w[i] = (PW+1)'(0) - diff_w[i];
			neg_w[i] = diff_w[i][PW];
			mag_w[i] = neg_w[i] ? negd_w[i][PW-1:0] : diff_w[i][PW-1:0];
			edir_w[i] = edge_q ? dir_q[i] : pdir_q[i];
		end
	end

	assign r_eff = (res_q == '0) ? pes_pkg::RES_W'(1) : res_q;
	assign mul_a = (state_q == pes_pkg::S_RR) ? {1'b0, r_eff} : mag_w[ax_q];
	assign product = mul_a * mul_a;

	assign len4 = {len_q, 2'b00};
	assign ge = SW'(len4) >= s_q;
	assign cnt_stop = !ge || (k_q == KW'(MAX_DIVISIONS + 1));
	assign ncnt_fin = ge ? k_q : ncnt_q;
	assign clip_fin = ncnt_fin == KW'(MAX_DIVISIONS + 1);

	always_comb begin
		if (clip_fin) begin
			n_fin = NW'(MAX_DIVISIONS);
		end else if (ncnt_fin == '0) begin
			n_fin = NW'(1);
		end else begin
			n_fin = ncnt_fin[NW-1:0];
		end
	end

	assign n_sel = n_q[edge_q];
	assign klast_w = edge_q ? (n_q[1] - NW'(1)) : n_q[0];
	assign emits_b = do_b_q && (n_q[1] != NW'(1));
	assign pk_nx = pk_q + NW'(1);
	assign pk_end = pk_nx == klast_w;
	assign two_n = {1'b0, n_sel, 1'b0};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_r[i] = rem_q[i] + {1'b0, r0_q[i]};
			carry_w[i] = sum_r[i] >= two_n;
			rem_nx[i] = carry_w[i] ? (sum_r[i] - two_n) : sum_r[i];
			q_nx[i] = q_q[i] + q0_q[i] + PW'(carry_w[i]);
			qx_w[i] = {1'b0, q_nx[i]};
			fx_w[i] = {from_w[i][PW-1], from_w[i]};
			pos_w[i] = neg_w[i] ? (fx_w[i] - qx_w[i]) : (fx_w[i] + qx_w[i]);
		end
	end

	assign div_in.start = state_q == pes_pkg::S_DIV_GO;
	assign div_in.done = 1'b0;

	pes_div #(
		.DW(PW),
		.VW(NW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(div_in),
		.ctl_out(div_out),
		.dividend(mag_w[ax_q]),
		.divisor(n_sel),
		.quot(div_quot),
		.rem(div_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pes_pkg::S_IDLE: begin
				if (s_tvalid) state_d = pes_pkg::S_RR;
			end
			pes_pkg::S_RR: begin
				if (echo_q && !do_b_q) state_d = pes_pkg::S_ECHO;
				else state_d = pes_pkg::S_LEN_MUL;
			end
			pes_pkg::S_LEN_MUL: state_d = pes_pkg::S_LEN_ACC;
			pes_pkg::S_LEN_ACC: begin
				if (ax_q == 2'd2) state_d = pes_pkg::S_CNT_INIT;
				else state_d = pes_pkg::S_LEN_MUL;
			end
			pes_pkg::S_CNT_INIT: state_d = pes_pkg::S_CNT;
			pes_pkg::S_CNT: begin
				if (cnt_stop) begin
					if (!edge_q && do_b_q) state_d = pes_pkg::S_LEN_MUL;
					else if (echo_q) state_d = pes_pkg::S_ECHO;
					else state_d = pes_pkg::S_DIV_GO;
				end
			end
			pes_pkg::S_DIV_GO: state_d = pes_pkg::S_DIV_WAIT;
			pes_pkg::S_DIV_WAIT: begin
				if (div_out.done) begin
					if (ax_q == 2'd2) state_d = pes_pkg::S_PT_INIT;
					else state_d = pes_pkg::S_DIV_GO;
				end
			end
			pes_pkg::S_PT_INIT: state_d = pes_pkg::S_PT_CALC;
			pes_pkg::S_PT_CALC: state_d = pes_pkg::S_OUT;
			pes_pkg::S_ECHO: state_d = pes_pkg::S_OUT;
			pes_pkg::S_OUT: begin
				if (m_tready) begin
					if (o_last_q) state_d = pes_pkg::S_IDLE;
					else if (part_end_q) state_d = pes_pkg::S_DIV_GO;
					else state_d = pes_pkg::S_PT_CALC;
				end
			end
			default: state_d = pes_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = state_q == pes_pkg::S_IDLE;
		m_tvalid = state_q == pes_pkg::S_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pes_pkg::S_IDLE;
			closed_q <= 1'b0;
			res_q <= pes_pkg::RES_RESET;
			started_q <= 1'b0;
			echo_q <= 1'b0;
			do_b_q <= 1'b0;
			last_q <= 1'b0;
			edge_q <= 1'b0;
			ax_q <= '0;
			k_q <= '0;
			ncnt_q <= '0;
			pk_q <= '0;
			for (int e = 0; e < 2; e++) begin
				n_q[e] <= NW'(1);
				clip_q[e] <= 1'b0;
			end
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
				prev_q[i] <= '0;
				pdir_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					pes_pkg::REG_CLOSED: closed_q <= cfg_data[0];
					pes_pkg::REG_RES: res_q <= cfg_data[pes_pkg::RES_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				pes_pkg::S_IDLE: begin
					if (s_tvalid) begin
						echo_q <= echo_w;
						do_b_q <= s_tlast && closed_q;
						last_q <= s_tlast;
						if (echo_w) begin
							for (int i = 0; i < 3; i++) start_q[i] <= pos_in[i];
						end
					end
				end
				pes_pkg::S_RR: begin
					ax_q <= '0;
					edge_q <= echo_q;
				end
				pes_pkg::S_LEN_ACC: begin
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
				pes_pkg::S_CNT_INIT: begin
					k_q <= KW'(1);
					ncnt_q <= '0;
				end
				pes_pkg::S_CNT: begin
					if (cnt_stop) begin
						n_q[edge_q] <= n_fin;
						clip_q[edge_q] <= clip_fin;
						ax_q <= '0;
						edge_q <= !edge_q && do_b_q;
					end else begin
						ncnt_q <= k_q;
						k_q <= k_q + KW'(1);
					end
				end
				pes_pkg::S_DIV_WAIT: begin
					if (div_out.done) ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
				pes_pkg::S_PT_INIT: pk_q <= '0;
				pes_pkg::S_PT_CALC: pk_q <= pk_nx;
				pes_pkg::S_OUT: begin
					if (m_tready) begin
						if (o_last_q) begin
							for (int i = 0; i < 3; i++) begin
								prev_q[i] <= cur_q[i];
								pdir_q[i] <= dir_q[i];
							end
							started_q <= !last_q;
						end else if (part_end_q) begin
							edge_q <= 1'b1;
							ax_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pes_pkg::S_IDLE: begin
				if (s_tvalid) begin
					for (int i = 0; i < 3; i++) begin
						cur_q[i] <= pos_in[i];
						dir_q[i] <= dir_in[i];
					end
				end
			end
			pes_pkg::S_RR: begin
				rr_q <= product[61:0];
				len_q <= '0;
			end
			pes_pkg::S_LEN_MUL: prod_q <= product;
			pes_pkg::S_LEN_ACC: len_q <= len_q + LW'(prod_q);
			pes_pkg::S_CNT_INIT: begin
				s_q <= SW'(rr_q);
				d_q <= SW'({rr_q, 3'b000});
			end
			pes_pkg::S_CNT: begin
				if (cnt_stop) begin
					len_q <= '0;
				end else begin
					s_q <= s_q + d_q;
					d_q <= d_q + SW'({rr_q, 3'b000});
				end
			end
			pes_pkg::S_DIV_WAIT: begin
				if (div_out.done) begin
					q0_q[ax_q] <= div_quot;
					r0_q[ax_q] <= {div_rem, 1'b0};
				end
			end
			pes_pkg::S_PT_INIT: begin
				for (int i = 0; i < 3; i++) begin
					q_q[i] <= '0;
					rem_q[i] <= RW'(n_sel);
				end
			end
			pes_pkg::S_PT_CALC: begin
				for (int i = 0; i < 3; i++) begin
					q_q[i] <= q_nx[i];
					rem_q[i] <= rem_nx[i];
					ox_q[i] <= pos_w[i][PW-1:0];
					od_q[i] <= edir_w[i];
				end
				o_has_q <= 1'b1;
				o_clip_q <= clip_q[edge_q];
				part_end_q <= pk_end;
				o_last_q <= pk_end && (edge_q || !emits_b);
			end
			pes_pkg::S_ECHO: begin
				for (int i = 0; i < 3; i++) begin
					ox_q[i] <= cur_q[i];
					od_q[i] <= '0;
				end
				o_has_q <= 1'b0;
				o_clip_q <= 1'b0;
				part_end_q <= 1'b1;
				o_last_q <= !emits_b;
			end
			default: ;
		endcase
	end

	assign m_tdata = {od_q[2], od_q[1], od_q[0], ox_q[2], ox_q[1], ox_q[0]};
	assign m_tuser = {o_clip_q, o_has_q};
	assign m_tlast = o_last_q;
endmodule
`default_nettype wire

### hdl/pes_div.sv
`default_nettype none
module pes_div #(
	parameter int DW = 32,
	parameter int VW = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pes_pkg::div_ctl_t    ctl_in,
	output pes_pkg::div_ctl_t         ctl_out,
	input  wire logic [DW-1:0]        dividend,
	input  wire logic [VW-1:0]        divisor,
	output logic [DW-1:0]             quot,
	output logic [VW-1:0]             rem
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [DW-1:0] quot_q;
	logic [VW-1:0] rem_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          fits;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits = trial >= {1'b0, divisor};
	assign diff = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quot_q <= {quot_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign ctl_out.start = busy_q;
	assign ctl_out.done = done_q;
	assign quot = quot_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
	logic [2:0][15:0] dir;
	logic [2:0][31:0] pos;
	logic first;
	logic last;
} node_t;

typedef struct packed {
	logic [2:0][15:0] dir;
	logic [2:0][31:0] pos;
	logic has_edge;
	logic run_end;
	logic clipped;
} point_t;

class subdiv_scoreboard;
	point_t pending[$];
	int errors;
	int n_points;
	int n_clipped;
	longint start_pos[3];
	longint prev_pos[3];
	logic [15:0] prev_dir[3];
	bit started;
	bit closed;
	longint unsigned res;

	function new();
		errors = 0;
		n_points = 0;
		n_clipped = 0;
		started = 0;
		closed = 0;
		res = 65536;
		for (int i = 0; i < 3; i++) begin
			start_pos[i] = 0;
			prev_pos[i] = 0;
			prev_dir[i] = 0;
		end
	endfunction

	function bit empty();
		return pending.size() == 0;
	endfunction

	function void config_reg(logic [0:0] idx, logic [30:0] val);
		if (idx == pes_pkg::REG_CLOSED)
			closed = val[0];
		else
			res = 64'(val);
	endfunction

	function void split_edge(longint from[3], longint to[3], logic [15:0] dir[3],
			bit drop_last);
		longint d[3];
		longint unsigned m[3];
		logic [127:0] len4;
		logic [127:0] rr;
		logic [127:0] tt;
		longint unsigned r;
		longint unsigned q;
		int n;
		bit clip;
		point_t p;
		len4 = 0;
		r = (res == 0) ? 64'd1 : res;
		rr = 128'(r) * 128'(r);
		for (int i = 0; i < 3; i++) begin
			d[i] = to[i] - from[i];
			m[i] = (d[i] < 0) ? -d[i] : d[i];
			len4 += 128'(m[i]) * 128'(m[i]);
		end
		len4 = len4 << 2;
		n = 0;
		for (int k = 1; k <= pes_pkg::MAX_DIVISIONS_DEF + 1; k++) begin
			tt = 128'(2 * k - 1);
			if (len4 < rr * tt * tt)
				break;
			n = k;
		end
		clip = n > pes_pkg::MAX_DIVISIONS_DEF;
		if (clip)
			n = pes_pkg::MAX_DIVISIONS_DEF;
		if (n < 1)
			n = 1;
		for (int k = 1; k <= n; k++) begin
			if (drop_last && k == n)
				break;
			for (int i = 0; i < 3; i++) begin
				q = (2 * m[i] * k + n) / (2 * n);
				p.pos[i] = 32'((d[i] < 0) ? from[i] - longint'(q) : from[i] + longint'(q));
				p.dir[i] = dir[i];
			end
			p.has_edge = 1;
			p.run_end = 0;
			p.clipped = clip;
			pending.push_back(p);
		end
	endfunction

	function void note(node_t nd);
		longint cur[3];
		logic [15:0] dir[3];
		point_t p;
		for (int i = 0; i < 3; i++) begin
			cur[i] = longint'($signed(nd.pos[i]));
			dir[i] = nd.dir[i];
		end
		if (nd.first || !started) begin
			for (int i = 0; i < 3; i++) begin
				p.pos[i] = nd.pos[i];
				p.dir[i] = 0;
				start_pos[i] = cur[i];
			end
			p.has_edge = 0;
			p.run_end = 0;
			p.clipped = 0;
			pending.push_back(p);
			started = 1;
		end else begin
			split_edge(prev_pos, cur, prev_dir, 0);
		end
		if (nd.last && closed)
			split_edge(cur, start_pos, dir, 1);
		for (int i = 0; i < 3; i++) begin
			prev_pos[i] = cur[i];
			prev_dir[i] = dir[i];
		end
		if (nd.last)
			started = 0;
		pending[$].run_end = 1;
	endfunction

	function void check(point_t got);
		point_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected point %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		n_points++;
		if (got.clipped)
			n_clipped++;
		for (int i = 0; i < 3; i++) begin
			if (got.pos[i] !== want.pos[i]) begin
				$display("%0t: pos[%0d] expected %h actual %h", $time, i, want.pos[i],
					got.pos[i]);
				errors++;
			end
			if (got.dir[i] !== want.dir[i]) begin
				$display("%0t: dir[%0d] expected %h actual %h", $time, i, want.dir[i],
					got.dir[i]);
				errors++;
			end
		end
		if (got.has_edge !== want.has_edge) begin
			$display("%0t: has_edge expected %b actual %b", $time, want.has_edge, got.has_edge);
			errors++;
		end
		if (got.run_end !== want.run_end) begin
			$display("%0t: run_end expected %b actual %b", $time, want.run_end, got.run_end);
			errors++;
		end
		if (got.clipped !== want.clipped) begin
			$display("%0t: clipped expected %b actual %b", $time, want.clipped, got.clipped);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [0:0] cfg_idx = 0;
	logic [pes_pkg::CFG_W-1:0] cfg_data = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [143:0] s_tdata = 0;
	logic [0:0] s_tuser = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [143:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	subdiv_scoreboard sb = new();
	int src_idle = 0;
	int snk_stall = 0;
	int hold_cycles = 0;
	int n_items = 0;
	logic [31:0] cur_pos[3];
	logic [30:0] cur_res = 65536;

	polyline_edge_subdivider u_top (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		point_t got;
		if (m_tvalid && m_tready) begin
			for (int i = 0; i < 3; i++) begin
				got.pos[i] = m_tdata[32*i +: 32];
				got.dir[i] = m_tdata[96 + 16*i +: 16];
			end
			got.has_edge = m_tuser[0];
			got.clipped = m_tuser[1];
			got.run_end = m_tlast;
			sb.check(got);
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 0;
		end else begin
			m_tready <= $urandom_range(99) >= snk_stall;
		end
	end

	task automatic send_node(node_t nd);
		int gap;
		for (int i = 0; i < 3; i++) begin
			s_tdata[32*i +: 32] <= nd.pos[i];
			s_tdata[96 + 16*i +: 16] <= nd.dir[i];
		end
		s_tuser <= nd.first;
		s_tlast <= nd.last;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note(nd);
		n_items++;
		gap = 0;
		while ($urandom_range(99) < src_idle && gap < 40)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (!sb.empty())
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_regs(bit closed, logic [30:0] res);
		cfg_we <= 1;
		cfg_idx <= pes_pkg::REG_CLOSED;
		cfg_data <= 31'(closed);
		@(posedge clk);
		cfg_idx <= pes_pkg::REG_RES;
		cfg_data <= res;
		@(posedge clk);
		cfg_we <= 0;
		sb.config_reg(pes_pkg::REG_CLOSED, 31'(closed));
		sb.config_reg(pes_pkg::REG_RES, res);
		cur_res = res;
		@(posedge clk);
	endtask

	function automatic node_t mk_node(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit first, bit last);
		node_t nd;
		nd.pos[0] = x;
		nd.pos[1] = y;
		nd.pos[2] = z;
		for (int i = 0; i < 3; i++)
			nd.dir[i] = 16'($urandom);
		nd.first = first;
		nd.last = last;
		return nd;
	endfunction

	// step near the resolution so counts stay small, sometimes far to saturate
	function automatic logic [31:0] step_coord(logic [31:0] p);
		longint unsigned r;
		longint unsigned mult;
		longint unsigned dlt;
		r = (cur_res == 0) ? 64'd1 : 64'(cur_res);
		mult = ($urandom_range(99) < 5) ? 64'($urandom_range(100)) : 64'($urandom_range(10));
		dlt = (r * mult) / 2;
		return $urandom_range(1) ? p + 32'(dlt) : p - 32'(dlt);
	endfunction

	task automatic run_polylines(int count);
		int len;
		int sent;
		node_t nd;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 15) begin
				nd = mk_node($urandom, $urandom, $urandom, 1'($urandom_range(1)),
					1'($urandom_range(1)));
				for (int i = 0; i < 3; i++)
					cur_pos[i] = nd.pos[i];
				send_node(nd);
				sent++;
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < 3; i++)
					cur_pos[i] = $urandom;
				for (int j = 0; j < len; j++) begin
					if (j > 0)
						for (int i = 0; i < 3; i++)
							cur_pos[i] = step_coord(cur_pos[i]);
					send_node(mk_node(cur_pos[0], cur_pos[1], cur_pos[2], j == 0,
						j == len - 1));
					sent++;
				end
			end
		end
	endtask

	initial begin
		bit closed_set[4];
		logic [30:0] res_set[4];
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed, reset settings first
		send_node(mk_node(32'h7fffffff, 32'h80000000, 32'h0, 1, 0));
		send_node(mk_node(32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0));
		send_node(mk_node(32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0));
		send_node(mk_node(32'h80008000, 32'h7fffffff, 32'hffffffff, 0, 1));
		send_node(mk_node(32'h00010000, 32'h00020000, 32'h0, 0, 0));
		send_node(mk_node(32'h00038000, 32'h00020000, 32'h0, 0, 0));
		send_node(mk_node(32'h0, 32'h0, 32'h0, 1, 0));
		send_node(mk_node(32'h00028000, 32'h0, 32'h0, 0, 1));
		drain();
		write_regs(1, 31'd65536);
		send_node(mk_node(32'h00050000, 32'h0, 32'h0, 1, 1));
		send_node(mk_node(32'h0, 32'h0, 32'h0, 1, 0));
		send_node(mk_node(32'h00030000, 32'h0, 32'h0, 0, 0));
		send_node(mk_node(32'h00030000, 32'h00040000, 32'hfffe0000, 0, 1));
		drain();
		write_regs(1, 31'd0);
		send_node(mk_node(32'h0, 32'h0, 32'h0, 1, 0));
		send_node(mk_node(32'h5, 32'hfffffffd, 32'h1, 0, 1));
		drain();
		write_regs(0, 31'h7fffffff);
		send_node(mk_node(32'h80000000, 32'h80000000, 32'h80000000, 1, 0));
		send_node(mk_node(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1));
		drain();
		write_regs(1, 31'd1);
		send_node(mk_node(32'h0, 32'h0, 32'h0, 1, 0));
		send_node(mk_node(32'h3, 32'h0, 32'h0, 0, 1));
		drain();

		// random phases, one idling pattern each
		closed_set[0] = 0; res_set[0] = 31'd65536;
		closed_set[1] = 1; res_set[1] = 31'h7fffffff;
		closed_set[2] = 1; res_set[2] = 31'($urandom_range(1, 32'h7fffffff));
		closed_set[3] = 1'($urandom_range(1)); res_set[3] = 31'd1;
		for (int ph = 0; ph < 4; ph++) begin
			write_regs(closed_set[ph], res_set[ph]);
			src_idle = (ph == 1 || ph == 3) ? 85 : 0;
			snk_stall = (ph == 2) ? 85 : (ph == 3) ? 12 : 0;
			if (ph == 3)
				src_idle = 12;
			if (ph == 0)
				hold_cycles <= 3000;
			run_polylines(60);
			drain();
		end

		$display("%0d nodes in, %0d points checked, %0d from saturated edges", n_items,
			sb.n_points, sb.n_clipped);
		$display("covered open and closed runs, extreme resolutions, and idle/stall patterns");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
